/* rtl/core/tls_sni_extractor_macros.svh */
// Assertion helpers for the checker file.
`ifndef TLS_SNI_EXTRACTOR_MACROS_SVH
`define TLS_SNI_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tse_pkg.sv */
`timescale 1ns / 1ps

package tse_pkg;

    localparam int POS_W = 17;
    localparam int LEN_W = 16;

    localparam logic [POS_W-1:0] POS_MAX   = '1;
    localparam logic [POS_W-1:0] OFF_SID   = 17'd43;
    localparam logic [POS_W-1:0] OFF_CS_HI = 17'd44;
    localparam logic [POS_W-1:0] OFF_CS_LO = 17'd45;
    localparam logic [POS_W-1:0] OFF_NL_HI = 17'd57;
    localparam logic [POS_W-1:0] OFF_NL_LO = 17'd58;
    localparam logic [POS_W-1:0] OFF_NAME  = 17'd59;

    typedef enum logic [1:0] {
        ST_COMPLETE = 2'd0,
        ST_CUT      = 2'd1,
        ST_EARLY    = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       name_valid;
        logic       is_last;
        status_t    status;
    } out_word_t;

endpackage

/* rtl/core/tse_stream_if.sv */
`timescale 1ns / 1ps

interface tse_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/tse_parse.sv */
`timescale 1ns / 1ps

module tse_parse #(
    parameter int MAX_NAME = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  tse_pkg::in_word_t  word,
    output logic               res_valid,
    output tse_pkg::out_word_t res
);

    localparam int CNT_W = $clog2(MAX_NAME + 1);

    logic [tse_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                sid_reg, sid_next;
    logic [tse_pkg::LEN_W-1:0] cs_reg, cs_next;
    logic [tse_pkg::LEN_W-1:0] nl_reg, nl_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      done_reg, done_next;

    logic [tse_pkg::POS_W-1:0] sid_ext;
    logic [tse_pkg::POS_W-1:0] base;
    logic                      at_sid, at_cs_hi, at_cs_lo, at_nl_hi, at_nl_lo, in_name;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      emitted;

    assign sid_ext  = tse_pkg::POS_W'(sid_reg);
    assign base     = sid_ext + tse_pkg::POS_W'(cs_reg);
    assign at_sid   = (pos_reg == tse_pkg::OFF_SID);
    assign at_cs_hi = (pos_reg == tse_pkg::OFF_CS_HI + sid_ext);
    assign at_cs_lo = (pos_reg == tse_pkg::OFF_CS_LO + sid_ext);
    assign at_nl_hi = (pos_reg == tse_pkg::OFF_NL_HI + base);
    assign at_nl_lo = (pos_reg == tse_pkg::OFF_NL_LO + base);
    assign in_name  = (pos_reg >= tse_pkg::OFF_NAME + base);
    assign cnt_inc  = cnt_reg + 1'b1;

    always_comb
    begin
        pos_next  = pos_reg;
        sid_next  = sid_reg;
        cs_next   = cs_reg;
        nl_next   = nl_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        emitted   = 1'b0;
        res_valid = 1'b0;
        res.name_byte  = '0;
        res.name_valid = 1'b0;
        res.is_last    = 1'b0;
        res.status     = tse_pkg::ST_COMPLETE;
        if (step)
        begin
            priority if (at_sid)
            begin
                sid_next = word.data_byte;
            end
            else if (at_cs_hi)
            begin
                cs_next = {word.data_byte, cs_reg[7:0]};
            end
            else if (at_cs_lo)
            begin
                cs_next = {cs_reg[15:8], word.data_byte};
            end
            else if (at_nl_hi)
            begin
                nl_next = {word.data_byte, nl_reg[7:0]};
            end
            else if (at_nl_lo)
            begin
                nl_next = {nl_reg[15:8], word.data_byte};
                if (!done_reg && nl_next == '0)
                begin
                    // empty name: status-only completion
                    done_next   = 1'b1;
                    res_valid   = 1'b1;
                    res.is_last = 1'b1;
                end
            end
            else if (in_name && !done_reg)
            begin
                cnt_next       = cnt_inc;
                emitted        = 1'b1;
                res_valid      = 1'b1;
                res.name_byte  = word.data_byte;
                res.name_valid = 1'b1;
                priority if (tse_pkg::LEN_W'(cnt_inc) == nl_reg)
                begin
                    done_next   = 1'b1;
                    res.is_last = 1'b1;
                end
                else if (cnt_inc >= CNT_W'(MAX_NAME))
                begin
                    done_next   = 1'b1;
                    res.is_last = 1'b1;
                    res.status  = tse_pkg::ST_CUT;
                end
                else if (word.packet_end)
                begin
                    done_next   = 1'b1;
                    res.is_last = 1'b1;
                    res.status  = tse_pkg::ST_EARLY;
                end
                else
                begin
                    res.is_last = 1'b0;
                end
            end
            else
            begin
                emitted = 1'b0;
            end

            if (word.packet_end && !done_next && !emitted && !res_valid)
            begin
                res_valid   = 1'b1;
                res.is_last = 1'b1;
                res.status  = tse_pkg::ST_EARLY;
            end

            if (word.packet_end)
            begin
                pos_next  = '0;
                sid_next  = '0;
                cs_next   = '0;
                nl_next   = '0;
                cnt_next  = '0;
                done_next = 1'b0;
            end
            else if (pos_reg != tse_pkg::POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sid_reg  <= '0;
            cs_reg   <= '0;
            nl_reg   <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            sid_reg  <= sid_next;
            cs_reg   <= cs_next;
            nl_reg   <= nl_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

endmodule

/* rtl/core/tls_sni_extractor.sv */
// TLS ClientHello server name extractor.
// pkt: payload bytes of one TCP packet, one word per byte, starting at the
//   TLS record header; packet_end marks the last byte of the packet.
// sni: server name bytes in order (name_valid = 1), at most MAX_NAME of them.
//   Each packet that reaches its name or ends gets exactly one word with
//   is_last = 1; status then tells complete, cut at MAX_NAME, or ended early.
//   A status-only word has name_valid = 0 and name_byte = 0.
// Fixed offsets: session id length at 43, suite length after it, name length
//   at 57+sid+cs, name from 59+sid+cs.
// Throughput: one byte per cycle, sustained while sni is ready.
// A result word reaches sni through the input register, then the parse step
//   into the output register.
// Bytes that produce no result are consumed without a sni word.
// Reset clears the parse state and the valid flags of both pipeline registers;
//   the block is ready right after reset. Parse state also clears after each packet_end.
// When sni stalls, the output register holds its word, the input register
//   takes one more byte, and pkt.ready then drops until sni drains.
`timescale 1ns / 1ps

module tls_sni_extractor #(
    parameter int MAX_NAME = 64
) (
    input logic           clk,
    input logic           rst_n,
    tse_stream_if.sink    pkt,
    tse_stream_if.source  sni
);

    logic               s1_valid_reg;
    tse_pkg::in_word_t  s1_word_reg;
    logic               out_valid_reg;
    tse_pkg::out_word_t out_word_reg;

    logic               out_free;
    logic               step;
    logic               res_valid;
    tse_pkg::out_word_t res;

    assign out_free    = !out_valid_reg || sni.ready;
    assign step        = s1_valid_reg && out_free;
    assign pkt.ready   = !s1_valid_reg || step;
    assign sni.valid   = out_valid_reg;
    assign sni.payload = out_word_reg;

    tse_parse #(
        .MAX_NAME (MAX_NAME)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .word      (s1_word_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pkt.valid && pkt.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (step && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sni.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            s1_word_reg <= pkt.payload;
        end
        if (step && res_valid)
        begin
            out_word_reg <= res;
        end
    end

endmodule

/* rtl/core/tse_checker.sv */
`timescale 1ns / 1ps
`include "tls_sni_extractor_macros.svh"

module tse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input tse_pkg::out_word_t out_word
);

    `TSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "sni word changed while stalled")
    `TSE_ASSERT_NOW(a_status_only_last, out_valid && !out_word.name_valid, out_word.is_last, "status-only word without is_last")
    `TSE_ASSERT_NOW(a_status_only_zero, out_valid && !out_word.name_valid, out_word.name_byte == 8'd0, "status-only word with nonzero byte")
    `TSE_ASSERT_NOW(a_mid_name, out_valid && !out_word.is_last, out_word.name_valid && (out_word.status == tse_pkg::ST_COMPLETE), "non-final word must be a plain name byte")

endmodule

bind tls_sni_extractor tse_checker u_tse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (sni.valid),
    .out_ready (sni.ready),
    .out_word  (sni.payload)
);
